[rtl/core/blr_pkg.sv]
// ----------------------------------------------------------------------------
// blr_pkg
// Shared constants and codes for the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 8;

  // color width (RGB565)
  localparam int COLOR_W = 16;

  // background color after reset
  localparam logic [COLOR_W-1:0] BG_RESET = 16'hFFFF;

  // every third point of a dotted line is a gap
  localparam logic [1:0] DOT_PERIOD = 2'd3;

  // depth of the command queue between front and walker
  localparam int QUEUE_DEPTH = 2;

  // operation codes of an input word
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

endpackage

`default_nettype wire

[rtl/core/blr_front.sv]
// ----------------------------------------------------------------------------
// blr_front
// Accepts input words, decodes start versus step, and precomputes the line
// setup (deltas, directions, initial error) of a start word.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_front #(
  parameter int C = blr_pkg::COORD_BITS_DEF
) (
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         operation_i,
  input  wire logic [C-1:0]                 x_start_i,
  input  wire logic [C-1:0]                 y_start_i,
  input  wire logic [C-1:0]                 x_end_i,
  input  wire logic [C-1:0]                 y_end_i,
  input  wire logic [blr_pkg::COLOR_W-1:0]  line_color_i,
  input  wire logic                         dotted_i,
  output logic                              q_push_o,
  input  wire logic                         q_ready_i,
  output logic [7*C+23:0]                   q_data_o
);

  typedef struct packed {
    blr_pkg::op_e                 op;
    logic [C-1:0]                 xs;
    logic [C-1:0]                 ys;
    logic [C-1:0]                 xe;
    logic [C-1:0]                 ye;
    logic [C-1:0]                 dx;
    logic [C:0]                   dyn;
    logic [C+2:0]                 err;
    logic                         x_neg;
    logic                         y_neg;
    logic [blr_pkg::COLOR_W-1:0]  color;
    logic                         dotted;
  } cmd_t;

  cmd_t         cmd;
  logic [C-1:0] dx;
  logic [C-1:0] dy_abs;
  logic [C:0]   dyn;

  // absolute deltas and negated y delta
  always_comb begin
    dx     = (x_end_i >= x_start_i) ? (x_end_i - x_start_i) : (x_start_i - x_end_i);
    dy_abs = (y_end_i >= y_start_i) ? (y_end_i - y_start_i) : (y_start_i - y_end_i);
    dyn    = (C+1)'(0) - {1'b0, dy_abs};
  end

  // build the command word
  always_comb begin
    cmd.op     = blr_pkg::op_e'(operation_i);
    cmd.xs     = x_start_i;
    cmd.ys     = y_start_i;
    cmd.xe     = x_end_i;
    cmd.ye     = y_end_i;
    cmd.dx     = dx;
    cmd.dyn    = dyn;
    cmd.err    = {3'b000, dx} + {{2{dyn[C]}}, dyn};
    cmd.x_neg  = !(x_start_i < x_end_i);
    cmd.y_neg  = !(y_start_i < y_end_i);
    cmd.color  = line_color_i;
    cmd.dotted = dotted_i;
  end

  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i;
  assign q_data_o   = cmd;

endmodule

`default_nettype wire

[rtl/core/blr_queue.sv]
// ----------------------------------------------------------------------------
// blr_queue
// Small FIFO of command words between the front and the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_queue #(
  parameter int W     = 80,
  parameter int DEPTH = blr_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [W-1:0]  data_i,
  output logic               ready_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output logic [W-1:0]       data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] count_q;

  assign ready_o = count_q < CW'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  // store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/blr_walker.sv]
// ----------------------------------------------------------------------------
// blr_walker
// Executes queued commands: loads a line on start, walks one Bresenham step
// per step word and registers the current point, the one before the step.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_walker #(
  parameter int C = blr_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [blr_pkg::COLOR_W-1:0]  background_color_i,
  input  wire logic                         q_valid_i,
  input  wire logic [7*C+23:0]              q_data_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [C-1:0]                      point_x_o,
  output logic [C-1:0]                      point_y_o,
  output logic [blr_pkg::COLOR_W-1:0]       point_color_o,
  output logic                              gap_o,
  output logic                              last_o
);

  typedef struct packed {
    blr_pkg::op_e                 op;
    logic [C-1:0]                 xs;
    logic [C-1:0]                 ys;
    logic [C-1:0]                 xe;
    logic [C-1:0]                 ye;
    logic [C-1:0]                 dx;
    logic [C:0]                   dyn;
    logic [C+2:0]                 err;
    logic                         x_neg;
    logic                         y_neg;
    logic [blr_pkg::COLOR_W-1:0]  color;
    logic                         dotted;
  } cmd_t;

  // line state
  logic [C-1:0]                 cur_x_q, cur_y_q, end_x_q, end_y_q;
  logic [C-1:0]                 dx_q;
  logic [C:0]                   dyn_q;
  logic signed [C+2:0]          err_q;
  logic                         x_neg_q, y_neg_q;
  logic [1:0]                   dot_cnt_q;
  logic [blr_pkg::COLOR_W-1:0]  color_q;
  logic                         dotted_q;
  logic                         active_q;
  logic [blr_pkg::COLOR_W-1:0]  bg_q;

  // output register
  logic                         out_valid_q;
  logic [C-1:0]                 pt_x_q, pt_y_q;
  logic [blr_pkg::COLOR_W-1:0]  pt_color_q;
  logic                         gap_q, last_q;

  // step datapath
  cmd_t                         cmd;
  logic                         is_start, out_free, pop, do_step;
  logic [1:0]                   dc_inc;
  logic                         gap;
  logic signed [C+3:0]          e2a, e2b, dyn_w, dx_w;
  logic signed [C+2:0]          err_x, err_y;
  logic [C-1:0]                 nx, ny;
  logic                         last;

  // decide whether the head command can retire this cycle
  always_comb begin
    cmd      = cmd_t'(q_data_i);
    is_start = cmd.op == blr_pkg::OP_START;
    out_free = !out_valid_q || out_ready_i;
    pop      = q_valid_i && (is_start || !active_q || out_free);
    do_step  = pop && !is_start && active_q;
  end

  // dotted-style gap and one Bresenham step
  always_comb begin
    dc_inc = dot_cnt_q + 2'd1;
    gap    = dotted_q && (dc_inc == blr_pkg::DOT_PERIOD);
    e2a    = {err_q, 1'b0};
    dyn_w  = {{3{dyn_q[C]}}, dyn_q};
    dx_w   = {4'b0000, dx_q};
    last   = 1'b0;
    err_x  = err_q;
    nx     = cur_x_q;
    ny     = cur_y_q;
    if (e2a >= dyn_w) begin
      if (cur_x_q == end_x_q) begin
        last = 1'b1;
      end else begin
        err_x = err_q + dyn_w[C+2:0];
        nx    = x_neg_q ? cur_x_q - C'(1) : cur_x_q + C'(1);
      end
    end
    e2b   = {err_x, 1'b0};
    err_y = err_x;
    if (!last && (e2b <= dx_w)) begin
      if (cur_y_q == end_y_q) begin
        last = 1'b1;
      end else begin
        err_y = err_x + dx_w[C+2:0];
        ny    = y_neg_q ? cur_y_q - C'(1) : cur_y_q + C'(1);
      end
    end
  end

  // hold line state, load on start, advance on step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
      dx_q      <= '0;
      dyn_q     <= '0;
      err_q     <= '0;
      x_neg_q   <= 1'b0;
      y_neg_q   <= 1'b0;
      dot_cnt_q <= '0;
      color_q   <= '0;
      dotted_q  <= 1'b0;
      active_q  <= 1'b0;
    end else if (pop && is_start) begin
      cur_x_q   <= cmd.xs;
      cur_y_q   <= cmd.ys;
      end_x_q   <= cmd.xe;
      end_y_q   <= cmd.ye;
      dx_q      <= cmd.dx;
      dyn_q     <= cmd.dyn;
      err_q     <= cmd.err;
      x_neg_q   <= cmd.x_neg;
      y_neg_q   <= cmd.y_neg;
      dot_cnt_q <= '0;
      color_q   <= cmd.color;
      dotted_q  <= cmd.dotted;
      active_q  <= 1'b1;
    end else if (do_step) begin
      cur_x_q   <= nx;
      cur_y_q   <= ny;
      err_q     <= err_y;
      dot_cnt_q <= gap ? 2'd0 : dc_inc;
      active_q  <= !last;
    end
  end

  // background color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q <= blr_pkg::BG_RESET;
    end else if (cfg_valid_i) begin
      bg_q <= background_color_i;
    end
  end

  // output valid: set on a step, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (do_step) begin
      pt_x_q     <= cur_x_q;
      pt_y_q     <= cur_y_q;
      pt_color_q <= gap ? bg_q : color_q;
      gap_q      <= gap;
      last_q     <= last;
    end
  end

  assign q_pop_o       = pop;
  assign out_valid_o   = out_valid_q;
  assign point_x_o     = pt_x_q;
  assign point_y_o     = pt_y_q;
  assign point_color_o = pt_color_q;
  assign gap_o         = gap_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

[rtl/core/bresenham_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Integer Bresenham line walker with an optional dotted style.
// ----------------------------------------------------------------------------
// A start word loads both endpoints, the line color and the dotted flag and
// gives no point; each following step word gives one point from the start to
// the end point, with last set on the end point. A step while no line is
// active is dropped. In dotted mode every third point is painted in the
// background color register. The block takes one word per clock and gives
// one point per clock while the output is not stalled; an accepted step word
// is written into the queue, and the walker then pops it and steps it into
// the output register.
// The walker's combinational error update sets the rate. A two-entry queue
// lets input continue while the output is stalled. The background color may
// be written only while no line is in progress; writes are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [blr_pkg::COLOR_W-1:0]  background_color_i,
  // input words
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         operation_i,
  input  wire logic [COORD_BITS-1:0]        x_start_i,
  input  wire logic [COORD_BITS-1:0]        y_start_i,
  input  wire logic [COORD_BITS-1:0]        x_end_i,
  input  wire logic [COORD_BITS-1:0]        y_end_i,
  input  wire logic [blr_pkg::COLOR_W-1:0]  line_color_i,
  input  wire logic                         dotted_i,
  // output points
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [COORD_BITS-1:0]             point_x_o,
  output logic [COORD_BITS-1:0]             point_y_o,
  output logic [blr_pkg::COLOR_W-1:0]       point_color_o,
  output logic                              gap_o,
  output logic                              last_o
);

  localparam int CMD_W = 7 * COORD_BITS + 24;

  logic              q_push, q_ready, q_valid, q_pop;
  logic [CMD_W-1:0]  q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  // decode and set up lines
  blr_front #(
    .C (COORD_BITS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .line_color_i (line_color_i),
    .dotted_i     (dotted_i),
    .q_push_o     (q_push),
    .q_ready_i    (q_ready),
    .q_data_o     (q_wdata)
  );

  // decouple front from walker
  blr_queue #(
    .W     (CMD_W),
    .DEPTH (blr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // walk lines and emit points
  blr_walker #(
    .C (COORD_BITS)
  ) u_walker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .background_color_i (background_color_i),
    .q_valid_i          (q_valid),
    .q_data_i           (q_rdata),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .point_x_o          (point_x_o),
    .point_y_o          (point_y_o),
    .point_color_o      (point_color_o),
    .gap_o              (gap_o),
    .last_o             (last_o)
  );

endmodule

`default_nettype wire

[rtl/core/blr_checker.sv]
// ----------------------------------------------------------------------------
// blr_checker
// Port-level checks for the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_checker #(
  parameter int C = blr_pkg::COORD_BITS_DEF
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         operation_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [C-1:0]                 point_x_o,
  input wire logic [C-1:0]                 point_y_o,
  input wire logic [blr_pkg::COLOR_W-1:0]  point_color_o,
  input wire logic                         gap_o,
  input wire logic                         last_o
);

  logic seen_step_q;

  // remember that a step word has been taken since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_step_q <= 1'b0;
    end else if (in_valid_i && in_ready_o && (operation_i == blr_pkg::OP_STEP)) begin
      seen_step_q <= 1'b1;
    end
  end

  // no point is shown directly after reset is sampled low
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("point valid during reset");

  // a stalled point holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(point_x_o) &&
      $stable(point_y_o) && $stable(point_color_o) && $stable(gap_o) && $stable(last_o))
    else $error("stalled point changed");

  // a point needs an earlier step word
  a_point_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> seen_step_q)
    else $error("point without a step word");

  // input back-pressure only follows an output stall
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without output stall");

endmodule

bind bresenham_line_rasterizer blr_checker #(.C(COORD_BITS)) u_blr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .point_x_o     (point_x_o),
  .point_y_o     (point_y_o),
  .point_color_o (point_color_o),
  .gap_o         (gap_o),
  .last_o        (last_o)
);

`default_nettype wire
